FILE: hw/rtl/kxd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kxd_pkg
// Shared constants, operation codes and the controller-to-datapath command
// struct for the keyed table XOR stream decoder.
// ----------------------------------------------------------------------------
package kxd_pkg;

  localparam int WORD_W      = 32;
  localparam int TABLE_DEPTH = 256;
  localparam int TABLE_AW    = $clog2(TABLE_DEPTH);

  localparam logic [WORD_W-1:0] SEED_MASK  = 32'h5555_5555;
  localparam logic [WORD_W-1:0] TABLE_MULT = 32'd39916801;

  localparam logic [1:0] OP_SEED = 2'd0;
  localparam logic [1:0] OP_BYTE = 2'd1;
  localparam logic [1:0] OP_HALF = 2'd2;
  localparam logic [1:0] OP_WORD = 2'd3;

  typedef struct packed {
    logic                load;   // beat accepted: capture item, form result
    logic                build;  // write one table entry
    logic                acc;    // fold RAM read data into the key
    logic [TABLE_AW-1:0] idx;    // table index or byte select
  } dp_cmd_t;

endpackage : kxd_pkg
`default_nettype wire

FILE: hw/rtl/kxd_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kxd_ram
// Generic single-port RAM, one write or read per cycle, registered read.
// ----------------------------------------------------------------------------
module kxd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule : kxd_ram
`default_nettype wire

FILE: hw/rtl/kxd_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kxd_dpath
// Datapath: running key, table generator, key table RAM and result register.
// ----------------------------------------------------------------------------
module kxd_dpath (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire kxd_pkg::dp_cmd_t            cmd,
  input  wire logic [1:0]                  op,
  input  wire logic [kxd_pkg::WORD_W-1:0]  raw,
  output logic      [kxd_pkg::WORD_W-1:0]  out_data
);

  logic [kxd_pkg::WORD_W-1:0]   key;
  logic [kxd_pkg::WORD_W-1:0]   gen;
  logic [kxd_pkg::WORD_W-1:0]   raw_q;
  logic [kxd_pkg::WORD_W-1:0]   raw_m;
  logic [kxd_pkg::WORD_W-1:0]   width_mask;
  logic [kxd_pkg::WORD_W-1:0]   prod;
  logic [kxd_pkg::WORD_W-1:0]   rd_data;
  logic [kxd_pkg::TABLE_AW-1:0] addr;
  logic [7:0]                   byte_sel;

  // Cut the raw value to the item width.
  always_comb begin
    unique case (op)
      kxd_pkg::OP_BYTE: width_mask = 32'h0000_00FF;
      kxd_pkg::OP_HALF: width_mask = 32'h0000_FFFF;
      default:          width_mask = 32'hFFFF_FFFF;
    endcase
    raw_m = raw & width_mask;
  end

  // Rotate right by one, then multiply, modulo 2^32.
  assign prod = {gen[0], gen[kxd_pkg::WORD_W-1:1]} * kxd_pkg::TABLE_MULT;

  assign byte_sel = raw_q[cmd.idx[1:0]*8 +: 8];
  assign addr     = cmd.build ? cmd.idx : byte_sel;

  kxd_ram #(
    .WIDTH (kxd_pkg::WORD_W),
    .DEPTH (kxd_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (cmd.build),
    .addr  (addr),
    .wdata (prod),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (cmd.load && op == kxd_pkg::OP_SEED) begin
      key <= raw ^ kxd_pkg::SEED_MASK;
    end else if (cmd.acc) begin
      key <= key ^ rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      raw_q    <= raw_m;
      out_data <= (op == kxd_pkg::OP_SEED) ? '0 : ((raw_m ^ key) & width_mask);
      if (op == kxd_pkg::OP_SEED) begin
        gen <= raw ^ kxd_pkg::SEED_MASK;
      end
    end else if (cmd.build) begin
      gen <= prod;
    end
  end

endmodule : kxd_dpath
`default_nettype wire

FILE: hw/rtl/kxd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kxd_ctrl
// Controller: input/output handshake, table build sweep and key fold
// sequencing.
// ----------------------------------------------------------------------------
module kxd_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [1:0]       op,
  input  wire logic             upd,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output kxd_pkg::dp_cmd_t      cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_BUILD = 2'd1;
  localparam logic [1:0] ST_FOLD  = 2'd2;
  localparam logic [1:0] ST_DRAIN = 2'd3;

  logic [1:0]                   state;
  logic [1:0]                   state_next;
  logic [kxd_pkg::TABLE_AW-1:0] cnt;
  logic [kxd_pkg::TABLE_AW-1:0] cnt_next;
  logic [1:0]                   last;
  logic [1:0]                   last_next;
  logic                         rd_valid;
  logic                         rd_valid_next;
  logic                         accept;

  assign s_tready = (state == ST_IDLE) && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    last_next     = last;
    rd_valid_next = 1'b0;
    cmd.load      = accept;
    cmd.build     = 1'b0;
    cmd.acc       = rd_valid;
    cmd.idx       = cnt;
    unique case (state)
      ST_IDLE: begin
        cnt_next = '0;
        if (accept) begin
          if (op == kxd_pkg::OP_SEED) begin
            state_next = ST_BUILD;
          end else if (upd) begin
            state_next = ST_FOLD;
            case (op)
              kxd_pkg::OP_BYTE: last_next = 2'd0;
              kxd_pkg::OP_HALF: last_next = 2'd1;
              default:          last_next = 2'd3;
            endcase
          end
        end
      end
      ST_BUILD: begin
        cmd.build = 1'b1;
        cnt_next  = cnt + 1'b1;
        if (cnt == kxd_pkg::TABLE_AW'(kxd_pkg::TABLE_DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_FOLD: begin
        // issue a read of the table entry for byte cnt
        rd_valid_next = 1'b1;
        cnt_next      = cnt + 1'b1;
        if (cnt[1:0] == last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      last     <= '0;
      rd_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      last     <= last_next;
      rd_valid <= rd_valid_next;
      if (accept) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  a_seed_builds: assert property (@(posedge clk) disable iff (rst)
    accept && op == kxd_pkg::OP_SEED |=> state == ST_BUILD && cnt == '0)
    else $error("seed beat did not start the table build");

  a_build_ends: assert property (@(posedge clk) disable iff (rst)
    state == ST_BUILD && cnt == kxd_pkg::TABLE_AW'(kxd_pkg::TABLE_DEPTH - 1)
    |=> state == ST_IDLE)
    else $error("table build did not end after the last entry");

  a_read_from_fold: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> $past(state) == ST_FOLD)
    else $error("key fold data without a read issued");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken while result register is held");

endmodule : kxd_ctrl
`default_nettype wire

FILE: hw/rtl/keyed_table_xor_stream_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_table_xor_stream_decoder
// Decodes a keyed, table-scrambled little-endian stream, one result per beat.
//
// Input beats carry the item kind in s_tuser (seed, byte, halfword, word) and
// the raw value plus the key update flag in s_tdata. Each accepted beat gives
// exactly one output beat on m_*, registered: m_tvalid rises the cycle after
// the input beat is taken. A seed beat returns zero, loads the key and then
// sweeps the 256-entry key table, one entry per cycle through a single
// rotate-and-multiply unit and the table RAM write port. A data beat without
// key update leaves the controller idle. With update, the table RAM read port
// is stepped once per raw byte, and a drain state then takes the last read.
// Synchronous reset clears the key to zero and drops any pending result; the
// table holds no meaningful value until the first seed. While the receiver
// stalls, the result is held and at most the work of one item runs on; the
// next beat is refused until the held result is taken.
// ----------------------------------------------------------------------------
module keyed_table_xor_stream_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // [31:0] raw_data, [32] update_key, zeros above
  input  wire logic [1:0]  s_tuser,   // [1:0] operation
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata    // [31:0] decoded_value
);

  kxd_pkg::dp_cmd_t cmd;

  kxd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .op       (s_tuser),
    .upd      (s_tdata[32]),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  kxd_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .op       (s_tuser),
    .raw      (s_tdata[31:0]),
    .out_data (m_tdata)
  );

endmodule : keyed_table_xor_stream_decoder
`default_nettype wire

FILE: tb/keyed_table_xor_stream_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_table_xor_stream_decoder_tb
// Self-checking bench for the keyed table XOR stream decoder. A short table of
// directed beats covers each item kind, the field extremes, seed beats and
// wide raw data. Random beats follow in phases of sender idling and receiver
// stalls, with one long receiver hold-off. Each output beat is compared with a
// local key and table predictor or with a directed row's typed-in value.
// ----------------------------------------------------------------------------
module keyed_table_xor_stream_decoder_tb;
  import kxd_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 300;   // covers the table sweep
  localparam int STALL_LIMIT  = 4000;
  localparam int N_DIRECTED   = 20;

  typedef enum int {PH_FREE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH} idle_phase_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] raw;
    logic        upd;
    bit          typed;   // use typed-in value instead of the predictor
    logic [31:0] want;
  } stim_row_t;

  // Before the first seed the table is unwritten: no key update there.
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    '{OP_BYTE, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'h0000_00FF},
    '{OP_HALF, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'h0000_FFFF},
    '{OP_WORD, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'hFFFF_FFFF},
    '{OP_WORD, 32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000},
    '{OP_SEED, 32'h5555_5555, 1'b1, 1'b1, 32'h0000_0000},
    '{OP_WORD, 32'h1234_5678, 1'b1, 1'b1, 32'h1234_5678},
    '{OP_SEED, 32'hAAAA_AAAA, 1'b0, 1'b1, 32'h0000_0000},
    '{OP_BYTE, 32'h0000_0000, 1'b0, 1'b1, 32'h0000_00FF},
    '{OP_HALF, 32'h0000_0000, 1'b0, 1'b1, 32'h0000_FFFF},
    '{OP_WORD, 32'h0000_0000, 1'b0, 1'b1, 32'hFFFF_FFFF},
    '{OP_BYTE, 32'hFFFF_FF00, 1'b1, 1'b0, 32'h0},
    '{OP_HALF, 32'hABCD_1234, 1'b1, 1'b0, 32'h0},
    '{OP_WORD, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0},
    '{OP_WORD, 32'h0000_0000, 1'b1, 1'b0, 32'h0},
    '{OP_SEED, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
    '{OP_HALF, 32'h0000_FFFF, 1'b1, 1'b0, 32'h0},
    '{OP_BYTE, 32'h0000_0080, 1'b1, 1'b0, 32'h0},
    '{OP_SEED, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'h0000_0000},
    '{OP_WORD, 32'h8000_0001, 1'b1, 1'b0, 32'h0},
    '{OP_WORD, 32'h7FFF_FFFE, 1'b0, 1'b0, 32'h0}
  };

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata  = '0;   // [31:0] raw_data, [32] update_key, zeros above
  logic [1:0]  s_tuser  = OP_WORD;   // [1:0] operation
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;   // [31:0] decoded_value

  keyed_table_xor_stream_decoder DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #10 clk = ~clk;

  idle_phase_t phase     = PH_FREE;
  logic        hold_req  = 1'b0;
  logic        hold_done = 1'b0;
  int          hold_cnt  = 0;

  // Predictor state
  logic [31:0] run_key;
  logic [31:0] key_tbl [TABLE_DEPTH];
  bit          seeded;

  logic [31:0] decoded_q [$];
  int          beats_in;
  int          kind_cnt [4];
  int          results_checked;
  int          mismatch_cnt;
  int          idle_cycles;

  function automatic logic [31:0] next_entry(logic [31:0] v);
    return {v[0], v[31:1]} * TABLE_MULT;
  endfunction

  // Return the decoded value of one beat and advance the key and table.
  function automatic logic [31:0] decode_and_advance(logic [1:0] op, logic [31:0] raw,
                                                     logic upd);
    logic [31:0] v;
    logic [31:0] mask;
    logic [31:0] fold;
    int          nbytes;
    int          i;
    if (op == OP_SEED) begin
      v = raw ^ SEED_MASK;
      run_key = v;
      for (i = 0; i < TABLE_DEPTH; i++) begin
        v = next_entry(v);
        key_tbl[i] = v;
      end
      seeded = 1'b1;
      return '0;
    end
    case (op)
      OP_BYTE: begin mask = 32'h0000_00FF; nbytes = 1; end
      OP_HALF: begin mask = 32'h0000_FFFF; nbytes = 2; end
      default: begin mask = 32'hFFFF_FFFF; nbytes = 4; end
    endcase
    raw  = raw & mask;
    v    = (raw ^ run_key) & mask;
    fold = '0;
    for (i = 0; i < nbytes; i++)
      fold = fold ^ key_tbl[raw[8*i +: 8]];
    if (upd)
      run_key = run_key ^ fold;
    return v;
  endfunction

  task automatic send_beat(input logic [1:0] op, input logic [31:0] raw, input logic upd,
                           input bit typed, input logic [31:0] typed_val);
    logic        rdy;
    logic [31:0] pred;
    int          idle_pct;
    idle_pct = (phase == PH_SEND_IDLE) ? 82 : (phase == PH_BOTH) ? 20 : 0;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, upd, raw};
    s_tuser  <= op;
    // s_tready is settled by the falling edge; the beat moves on the next rise
    do begin
      @(negedge clk);
      rdy = s_tready;
      @(posedge clk);
    end while (!rdy);
    pred = decode_and_advance(op, raw, upd);
    decoded_q.push_back(typed ? typed_val : pred);
    beats_in++;
    kind_cnt[op]++;
  endtask

  task automatic send_random(input int count);
    logic [1:0]  op;
    logic [31:0] raw;
    logic        upd;
    int          pick;
    repeat (count) begin
      op  = ($urandom_range(15) == 0) ? OP_SEED : 2'($urandom_range(3, 1));
      pick = $urandom_range(9);
      case (pick)
        0:       raw = 32'h0000_0000;
        1:       raw = 32'hFFFF_FFFF;
        2:       raw = 32'h1 << $urandom_range(31);
        3:       raw = $urandom_range(255);
        default: raw = $urandom;
      endcase
      upd = seeded ? 1'($urandom_range(1)) : 1'b0;
      send_beat(op, raw, upd, 1'b0, '0);
    end
  endtask

  // Receiver: random stalls by phase, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready  <= 1'b0;
      hold_cnt  <= 0;
      hold_done <= 1'b0;
    end else if (hold_req && !hold_done) begin
      m_tready <= 1'b0;
      hold_cnt <= hold_cnt + 1;
      if (hold_cnt == HOLD_CYCLES - 1)
        hold_done <= 1'b1;
    end else begin
      case (phase)
        PH_RECV_STALL: m_tready <= ($urandom_range(99) >= 82);
        PH_BOTH:       m_tready <= ($urandom_range(99) >= 20);
        default:       m_tready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin : result_check
    logic [31:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (decoded_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("%0t: result beat %08h with nothing outstanding", $realtime, m_tdata);
      end else begin
        want = decoded_q.pop_front();
        results_checked++;
        if (m_tdata !== want) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: decoded_value mismatch: expected %08h, got %08h",
                     $realtime, want, m_tdata);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout: no beat moved for %0d cycles", STALL_LIMIT);
      $display("FAIL keyed_table_xor_stream_decoder");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int r;
    run_key         = '0;
    seeded          = 1'b0;
    beats_in        = 0;
    results_checked = 0;
    mismatch_cnt    = 0;
    idle_cycles     = 0;
    for (r = 0; r < 4; r++) kind_cnt[r] = 0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (r = 0; r < N_DIRECTED; r++)
      send_beat(DIRECTED[r].op, DIRECTED[r].raw, DIRECTED[r].upd,
                DIRECTED[r].typed, DIRECTED[r].want);

    // Long receiver hold-off while beats keep coming: input must back up
    hold_req <= 1'b1;
    send_random(20);
    hold_req <= 1'b0;

    send_random(95);
    phase <= PH_SEND_IDLE;
    send_random(95);
    phase <= PH_RECV_STALL;
    send_random(95);
    phase <= PH_BOTH;
    send_random(95);
    s_tvalid <= 1'b0;

    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d beats: %0d seeds, %0d bytes, %0d halfwords, %0d words",
             beats_in, kind_cnt[OP_SEED], kind_cnt[OP_BYTE], kind_cnt[OP_HALF],
             kind_cnt[OP_WORD]);
    $display("Checked %0d results under idle, stall and hold-off phases, %0d mismatches",
             results_checked, mismatch_cnt);
    if (mismatch_cnt == 0)
      $display("PASS keyed_table_xor_stream_decoder");
    else
      $display("FAIL keyed_table_xor_stream_decoder");
    $finish;
  end

endmodule
